/* rtl/oagi_pkg.sv */
// Shared types, constants and arithmetic helpers for the online AR gap imputer.
// No dependencies; imported by every module of the block.
`default_nettype none
package oagi_pkg;

    localparam int ORDER_DEF = 8;
    localparam int SAMPLE_W = 32;
    localparam int NORM_W = 62;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_CNT_W = 7;
    localparam logic [30:0] MAG_LIM = 31'h7FFF_FFFF;
    localparam logic [31:0] INV_SQRT2_Q30 = 32'd759250125;

    typedef struct packed {
        logic clear;
        logic push;
        logic rot;
    } oagi_cell_ctl_t;

    // round half away from zero, drop 30 fraction bits
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] q;
        m = v[63] ? (~v + 64'd1) : v;
        q = (m + 64'd536870912) >> 30;
        rnd30 = v[63] ? $signed(~q + 64'd1) : $signed(q);
    endfunction

    // clamp bound for lag k+1, Q1.30
    function automatic logic [31:0] bound_q30(input logic [4:0] k);
        logic [4:0] sh;
        logic [5:0] k1;
        if (k[0]) begin
            k1 = {1'b0, k} + 6'd1;
            sh = k1[5:1];
            bound_q30 = 32'd1 << (5'd30 - sh);
        end else begin
            sh = k >> 1;
            bound_q30 = INV_SQRT2_Q30 >> sh;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/oagi_cell.sv */
// One tap of the history/weight ring: holds one history sample and its weight.
// Depends on oagi_pkg for the control struct.
`default_nettype none
module oagi_cell (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire oagi_pkg::oagi_cell_ctl_t ctl,
    input  wire logic signed [31:0]      up_h,
    input  wire logic signed [31:0]      up_w,
    input  wire logic signed [31:0]      dn_h,
    output logic signed [31:0]           h,
    output logic signed [31:0]           w
);
    import oagi_pkg::*;

    logic signed [31:0] h_reg;
    logic signed [31:0] w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
            w_reg <= '0;
        end
        else if (ctl.clear)
        begin
            h_reg <= '0;
            w_reg <= '0;
        end
        else if (ctl.push)
        begin
            h_reg <= dn_h;
        end
        else if (ctl.rot)
        begin
            h_reg <= up_h;
            w_reg <= up_w;
        end
    end

    assign h = h_reg;
    assign w = w_reg;

endmodule
`default_nettype wire

/* rtl/oagi_div.sv */
// Restoring divider, one quotient bit per cycle, with a preloaded partial remainder.
// Depends on oagi_pkg for widths.
`default_nettype none
module oagi_div (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    input  wire [oagi_pkg::NORM_W-1:0]            rem_init,
    input  wire [oagi_pkg::DIV_NUM_W-1:0]         num_low,
    input  wire [oagi_pkg::DIV_CNT_W-1:0]         nbits,
    input  wire [oagi_pkg::NORM_W-1:0]            divisor,
    output logic                                  done,
    output logic [oagi_pkg::DIV_NUM_W-1:0]        quot
);
    import oagi_pkg::*;

    logic [NORM_W-1:0]    rem_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [NORM_W:0]      trial;
    logic [NORM_W:0]      diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge = trial >= {1'b0, divisor};
    assign diff = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            num_reg <= num_low;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

/* rtl/oagi_isqrt.sv */
// Bit-by-bit integer square root of a 64-bit value, one result bit per cycle.
// Depends on oagi_pkg.
`default_nettype none
module oagi_isqrt (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  wire [63:0]   value,
    output logic         done,
    output logic [31:0]  root
);
    import oagi_pkg::*;

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] rb;
    logic        ge;

    assign rb = r_reg + b_reg;
    assign ge = v_reg >= rb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (b_reg == 64'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && b_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            r_reg <= '0;
            b_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg <= v_reg - rb;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule
`default_nettype wire

/* rtl/online_ar_gap_imputer_core.sv */
// Online AR gap imputer: a ring of ORDER cells holding history and weights, a shared
// multiplier at the ring head, a bit-serial divider and a bit-serial square root.
// Depends on oagi_pkg, oagi_cell, oagi_div, oagi_isqrt.
//
// One item is worked at a time. A warm-up item (first ORDER of a series) goes from
// dispatch straight to the output stage; a missing sample makes one ring rotation
// through the head multiplier first. A present sample takes the norm pass, the 2^60/index
// division and the square root, then per tap a wait on the target division in the
// shared divider plus the product, step and clamp (the wait is skipped for a zero
// norm or a saturated target).
// A finished item waits in the output register while the next item is accepted.
`default_nettype none
module online_ar_gap_imputer_core #(
    parameter int ORDER = oagi_pkg::ORDER_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire logic signed [31:0]    sample_value,
    input  wire                        sample_missing,
    input  wire                        series_start,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic signed [31:0]         filled_value,
    output logic                       was_imputed
);
    import oagi_pkg::*;

    localparam int CNT_W = $clog2(ORDER + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_PRED  = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_RDIV  = 4'd4;
    localparam logic [3:0] S_RWAIT = 4'd5;
    localparam logic [3:0] S_RSQ   = 4'd6;
    localparam logic [3:0] S_SWAIT = 4'd7;
    localparam logic [3:0] S_TMUL  = 4'd8;
    localparam logic [3:0] S_TDIV  = 4'd9;
    localparam logic [3:0] S_TWAIT = 4'd10;
    localparam logic [3:0] S_TSTEP = 4'd11;
    localparam logic [3:0] S_TUPD  = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [31:0]  x_reg;
    logic                miss_reg;
    logic [31:0]         idx_reg;
    logic signed [63:0]  prod_reg;
    logic signed [39:0]  acc_reg;
    logic [NORM_W-1:0]   norm_reg;
    logic [30:0]         rate_reg;
    logic [30:0]         mag_reg;
    logic signed [63:0]  step_reg;
    logic signed [31:0]  res_reg;
    logic                imp_reg;
    logic                out_valid_reg;
    logic signed [31:0]  filled_reg;
    logic                imputed_reg;

    logic signed [31:0]  h_arr [ORDER];
    logic signed [31:0]  w_arr [ORDER];
    logic signed [31:0]  h0;
    logic signed [31:0]  w0;
    logic signed [31:0]  fb_w;
    oagi_cell_ctl_t      cell_ctl;

    logic                accept;
    logic                out_free;
    logic                cnt_end;
    logic                cnt_last;
    logic signed [63:0]  mul_hx;
    logic signed [39:0]  acc_sum;
    logic [NORM_W-1:0]   norm_sum;
    logic [31:0]         ah;
    logic [31:0]         ax;
    logic [63:0]         p_u;
    logic [NORM_W-1:0]   p_hi;
    logic signed [31:0]  tgt;
    logic signed [32:0]  diff;
    logic signed [64:0]  step_full;
    logic signed [33:0]  wsum;
    logic signed [33:0]  bnd;
    logic signed [31:0]  w_new;
    logic signed [31:0]  acc_sat;

    logic                div_start;
    logic [NORM_W-1:0]   div_rem;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_CNT_W-1:0] div_nbits;
    logic [NORM_W-1:0]   div_d;
    logic                div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic                sq_start;
    logic                sq_done;
    logic [31:0]         sq_root;

    assign h0 = h_arr[0];
    assign w0 = w_arr[0];

    assign accept = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_end = (cnt_reg == CNT_W'(ORDER));
    assign cnt_last = (cnt_reg == CNT_W'(ORDER - 1));

    assign mul_hx = h0 * ((state_reg == S_PRED) ? w0 : h0);
    assign acc_sum = acc_reg + 40'(rnd30(prod_reg));
    assign norm_sum = norm_reg + NORM_W'($unsigned(prod_reg) >> 6);

    assign ah = h0[31] ? (~h0 + 32'd1) : h0;
    assign ax = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign p_u = 64'(ah) * 64'(ax);
    assign p_hi = NORM_W'($unsigned(prod_reg) >> 7);

    assign tgt = (h0[31] ^ x_reg[31]) ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign diff = 33'(tgt) - 33'(w0);
    assign step_full = diff * $signed({1'b0, rate_reg});
    assign wsum = 34'(w0) + 34'(rnd30(step_reg));
    assign bnd = $signed({2'b00, bound_q30(5'(cnt_reg))});

    always_comb
    begin
        if (wsum >= bnd)
            w_new = 32'(bnd);
        else if (wsum <= -bnd)
            w_new = 32'(-bnd);
        else
            w_new = 32'(wsum);
    end

    always_comb
    begin
        if (acc_sum > 40'sd2147483647)
            acc_sat = 32'sh7FFF_FFFF;
        else if (acc_sum < -40'sd2147483648)
            acc_sat = 32'sh8000_0000;
        else
            acc_sat = 32'(acc_sum);
    end

    assign fb_w = (state_reg == S_TUPD) ? w_new : w0;

    assign cell_ctl.clear = accept && series_start;
    assign cell_ctl.push = (state_reg == S_FIN) && out_free;
    assign cell_ctl.rot = (((state_reg == S_PRED) || (state_reg == S_NORM)) && !cnt_end)
                          || (state_reg == S_TUPD);

    genvar gi;
    generate
        for (gi = 0; gi < ORDER; gi++)
        begin : g_cell
            logic signed [31:0] up_h;
            logic signed [31:0] up_w;
            logic signed [31:0] dn_h;
            if (gi == ORDER - 1)
            begin : g_tail
                assign up_h = h0;
                assign up_w = fb_w;
            end
            else
            begin : g_mid
                assign up_h = h_arr[gi + 1];
                assign up_w = w_arr[gi + 1];
            end
            if (gi == 0)
            begin : g_head
                assign dn_h = res_reg;
            end
            else
            begin : g_body
                assign dn_h = h_arr[gi - 1];
            end
            oagi_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (cell_ctl),
                .up_h  (up_h),
                .up_w  (up_w),
                .dn_h  (dn_h),
                .h     (h_arr[gi]),
                .w     (w_arr[gi])
            );
        end
    endgenerate

    assign div_start = (state_reg == S_RDIV)
                       || ((state_reg == S_TDIV) && (norm_reg != '0) && (p_hi < norm_reg));
    assign div_rem = (state_reg == S_RDIV) ? '0 : p_hi;
    assign div_num = (state_reg == S_RDIV) ? {1'b1, 63'd0} : {prod_reg[6:0], 57'd0};
    assign div_nbits = (state_reg == S_RDIV) ? DIV_CNT_W'(61) : DIV_CNT_W'(31);
    assign div_d = ((state_reg == S_RDIV) || (state_reg == S_RWAIT))
                   ? NORM_W'(idx_reg) : norm_reg;

    oagi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .num_low  (div_num),
        .nbits    (div_nbits),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign sq_start = (state_reg == S_RSQ);

    oagi_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (div_quot),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_DISP;
            S_DISP:
            begin
                if (idx_reg < 32'(ORDER))
                    state_next = S_FIN;
                else if (miss_reg)
                    state_next = S_PRED;
                else
                    state_next = S_NORM;
            end
            S_PRED:  if (cnt_end) state_next = S_FIN;
            S_NORM:  if (cnt_end) state_next = S_RDIV;
            S_RDIV:  state_next = S_RWAIT;
            S_RWAIT: if (div_done) state_next = S_RSQ;
            S_RSQ:   state_next = S_SWAIT;
            S_SWAIT: if (sq_done) state_next = S_TMUL;
            S_TMUL:  state_next = S_TDIV;
            S_TDIV:  state_next = div_start ? S_TWAIT : S_TSTEP;
            S_TWAIT: if (div_done) state_next = S_TSTEP;
            S_TSTEP: state_next = S_TUPD;
            S_TUPD:  state_next = cnt_last ? S_FIN : S_TMUL;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && series_start)
                        idx_reg <= '0;
                end
                S_DISP:  cnt_reg <= '0;
                S_PRED:  cnt_reg <= cnt_reg + 1'b1;
                S_NORM:  cnt_reg <= cnt_reg + 1'b1;
                S_SWAIT: cnt_reg <= '0;
                S_TUPD:  cnt_reg <= cnt_reg + 1'b1;
                S_FIN:
                begin
                    if (out_free && (idx_reg != 32'hFFFF_FFFF))
                        idx_reg <= idx_reg + 32'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_reg <= sample_value;
                    miss_reg <= sample_missing;
                end
            end
            S_DISP:
            begin
                acc_reg <= '0;
                norm_reg <= '0;
                res_reg <= miss_reg ? 32'sd0 : x_reg;
                imp_reg <= miss_reg;
            end
            S_PRED:
            begin
                if (!cnt_end)
                    prod_reg <= mul_hx;
                if (cnt_reg != '0)
                    acc_reg <= acc_sum;
                if (cnt_end)
                    res_reg <= acc_sat;
            end
            S_NORM:
            begin
                if (!cnt_end)
                    prod_reg <= mul_hx;
                if (cnt_reg != '0)
                    norm_reg <= norm_sum;
            end
            S_SWAIT:
            begin
                if (sq_done)
                    rate_reg <= sq_root[30:0];
            end
            S_TMUL:  prod_reg <= $signed(p_u);
            S_TDIV:
            begin
                if (norm_reg == '0)
                    mag_reg <= '0;
                else if (p_hi >= norm_reg)
                    mag_reg <= MAG_LIM;
            end
            S_TWAIT:
            begin
                if (div_done)
                    mag_reg <= div_quot[30:0];
            end
            S_TSTEP: step_reg <= 64'(step_full);
            S_FIN:
            begin
                if (out_free)
                begin
                    filled_reg <= res_reg;
                    imputed_reg <= imp_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign filled_value = filled_reg;
    assign was_imputed = imputed_reg;

endmodule
`default_nettype wire
